FILE: rtl/aes_round_datapath_macros.svh
// assertion macros for the aes round datapath
// no dependencies
`ifndef AES_ROUND_DATAPATH_MACROS_SVH
`define AES_ROUND_DATAPATH_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(label, rst_n, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_RST(label, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/aesr_pkg.sv
// shared types, constants, gf functions and sbox tables for the aes round datapath
// no dependencies
`default_nettype none
package aesr_pkg;
  localparam int unsigned NBYTES = 16;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_FULL  = 2'd1,
    CMD_FINAL = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef logic [7:0] byte_t;
  typedef byte_t [NBYTES-1:0] block_t;

  typedef struct packed {
    logic dir;
    logic do_sub;
    logic do_mix;
  } ctl_t;

  localparam byte_t [255:0] FWD_BOX = {
    8'h16,8'hbb,8'h54,8'hb0,8'h0f,8'h2d,8'h99,8'h41,8'h68,8'h42,8'he6,8'hbf,8'h0d,8'h89,8'ha1,8'h8c,
    8'hdf,8'h28,8'h55,8'hce,8'he9,8'h87,8'h1e,8'h9b,8'h94,8'h8e,8'hd9,8'h69,8'h11,8'h98,8'hf8,8'he1,
    8'h9e,8'h1d,8'hc1,8'h86,8'hb9,8'h57,8'h35,8'h61,8'h0e,8'hf6,8'h03,8'h48,8'h66,8'hb5,8'h3e,8'h70,
    8'h8a,8'h8b,8'hbd,8'h4b,8'h1f,8'h74,8'hdd,8'he8,8'hc6,8'hb4,8'ha6,8'h1c,8'h2e,8'h25,8'h78,8'hba,
    8'h08,8'hae,8'h7a,8'h65,8'hea,8'hf4,8'h56,8'h6c,8'ha9,8'h4e,8'hd5,8'h8d,8'h6d,8'h37,8'hc8,8'he7,
    8'h79,8'he4,8'h95,8'h91,8'h62,8'hac,8'hd3,8'hc2,8'h5c,8'h24,8'h06,8'h49,8'h0a,8'h3a,8'h32,8'he0,
    8'hdb,8'h0b,8'h5e,8'hde,8'h14,8'hb8,8'hee,8'h46,8'h88,8'h90,8'h2a,8'h22,8'hdc,8'h4f,8'h81,8'h60,
    8'h73,8'h19,8'h5d,8'h64,8'h3d,8'h7e,8'ha7,8'hc4,8'h17,8'h44,8'h97,8'h5f,8'hec,8'h13,8'h0c,8'hcd,
    8'hd2,8'hf3,8'hff,8'h10,8'h21,8'hda,8'hb6,8'hbc,8'hf5,8'h38,8'h9d,8'h92,8'h8f,8'h40,8'ha3,8'h51,
    8'ha8,8'h9f,8'h3c,8'h50,8'h7f,8'h02,8'hf9,8'h45,8'h85,8'h33,8'h4d,8'h43,8'hfb,8'haa,8'hef,8'hd0,
    8'hcf,8'h58,8'h4c,8'h4a,8'h39,8'hbe,8'hcb,8'h6a,8'h5b,8'hb1,8'hfc,8'h20,8'hed,8'h00,8'hd1,8'h53,
    8'h84,8'h2f,8'he3,8'h29,8'hb3,8'hd6,8'h3b,8'h52,8'ha0,8'h5a,8'h6e,8'h1b,8'h1a,8'h2c,8'h83,8'h09,
    8'h75,8'hb2,8'h27,8'heb,8'he2,8'h80,8'h12,8'h07,8'h9a,8'h05,8'h96,8'h18,8'hc3,8'h23,8'hc7,8'h04,
    8'h15,8'h31,8'hd8,8'h71,8'hf1,8'he5,8'ha5,8'h34,8'hcc,8'hf7,8'h3f,8'h36,8'h26,8'h93,8'hfd,8'hb7,
    8'hc0,8'h72,8'ha4,8'h9c,8'haf,8'ha2,8'hd4,8'had,8'hf0,8'h47,8'h59,8'hfa,8'h7d,8'hc9,8'h82,8'hca,
    8'h76,8'hab,8'hd7,8'hfe,8'h2b,8'h67,8'h01,8'h30,8'hc5,8'h6f,8'h6b,8'hf2,8'h7b,8'h77,8'h7c,8'h63
  };

  localparam byte_t [255:0] INV_BOX = {
    8'h7d,8'h0c,8'h21,8'h55,8'h63,8'h14,8'h69,8'he1,8'h26,8'hd6,8'h77,8'hba,8'h7e,8'h04,8'h2b,8'h17,
    8'h61,8'h99,8'h53,8'h83,8'h3c,8'hbb,8'heb,8'hc8,8'hb0,8'hf5,8'h2a,8'hae,8'h4d,8'h3b,8'he0,8'ha0,
    8'hef,8'h9c,8'hc9,8'h93,8'h9f,8'h7a,8'he5,8'h2d,8'h0d,8'h4a,8'hb5,8'h19,8'ha9,8'h7f,8'h51,8'h60,
    8'h5f,8'hec,8'h80,8'h27,8'h59,8'h10,8'h12,8'hb1,8'h31,8'hc7,8'h07,8'h88,8'h33,8'ha8,8'hdd,8'h1f,
    8'hf4,8'h5a,8'hcd,8'h78,8'hfe,8'hc0,8'hdb,8'h9a,8'h20,8'h79,8'hd2,8'hc6,8'h4b,8'h3e,8'h56,8'hfc,
    8'h1b,8'hbe,8'h18,8'haa,8'h0e,8'h62,8'hb7,8'h6f,8'h89,8'hc5,8'h29,8'h1d,8'h71,8'h1a,8'hf1,8'h47,
    8'h6e,8'hdf,8'h75,8'h1c,8'he8,8'h37,8'hf9,8'he2,8'h85,8'h35,8'had,8'he7,8'h22,8'h74,8'hac,8'h96,
    8'h73,8'he6,8'hb4,8'hf0,8'hce,8'hcf,8'hf2,8'h97,8'hea,8'hdc,8'h67,8'h4f,8'h41,8'h11,8'h91,8'h3a,
    8'h6b,8'h8a,8'h13,8'h01,8'h03,8'hbd,8'haf,8'hc1,8'h02,8'h0f,8'h3f,8'hca,8'h8f,8'h1e,8'h2c,8'hd0,
    8'h06,8'h45,8'hb3,8'hb8,8'h05,8'h58,8'he4,8'hf7,8'h0a,8'hd3,8'hbc,8'h8c,8'h00,8'hab,8'hd8,8'h90,
    8'h84,8'h9d,8'h8d,8'ha7,8'h57,8'h46,8'h15,8'h5e,8'hda,8'hb9,8'hed,8'hfd,8'h50,8'h48,8'h70,8'h6c,
    8'h92,8'hb6,8'h65,8'h5d,8'hcc,8'h5c,8'ha4,8'hd4,8'h16,8'h98,8'h68,8'h86,8'h64,8'hf6,8'hf8,8'h72,
    8'h25,8'hd1,8'h8b,8'h6d,8'h49,8'ha2,8'h5b,8'h76,8'hb2,8'h24,8'hd9,8'h28,8'h66,8'ha1,8'h2e,8'h08,
    8'h4e,8'hc3,8'hfa,8'h42,8'h0b,8'h95,8'h4c,8'hee,8'h3d,8'h23,8'hc2,8'ha6,8'h32,8'h94,8'h7b,8'h54,
    8'hcb,8'he9,8'hde,8'hc4,8'h44,8'h43,8'h8e,8'h34,8'h87,8'hff,8'h2f,8'h9b,8'h82,8'h39,8'he3,8'h7c,
    8'hfb,8'hd7,8'hf3,8'h81,8'h9e,8'ha3,8'h40,8'hbf,8'h38,8'ha5,8'h36,8'h30,8'hd5,8'h6a,8'h09,8'h52
  };

  function automatic byte_t xt(input byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // mix one column, forward or inverse coefficients
  function automatic logic [31:0] mix_col(input byte_t [3:0] c, input logic inv);
    byte_t [3:0] o;
    byte_t [3:0] x2;
    byte_t [3:0] x4;
    byte_t [3:0] x8;
    for (int i = 0; i < 4; i++) begin
      x2[i] = xt(c[i]);
      x4[i] = xt(x2[i]);
      x8[i] = xt(x4[i]);
    end
    for (int r = 0; r < 4; r++) begin
      if (!inv) begin
        o[r] = x2[r] ^ (x2[(r+1)%4] ^ c[(r+1)%4]) ^ c[(r+2)%4] ^ c[(r+3)%4];
      end else begin
        o[r] = (x8[r] ^ x4[r] ^ x2[r])
             ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ c[(r+1)%4])
             ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ c[(r+2)%4])
             ^ (x8[(r+3)%4] ^ c[(r+3)%4]);
      end
    end
    return o;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/aesr_stream_if.sv
// valid/ready channel interface carrying a generic payload
// no dependencies
`default_nettype none
interface aesr_stream_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/aesr_mix.sv
// mix columns stage over the whole block, bypass when not selected
// depends on aesr_pkg
`default_nettype none
module aesr_mix (
  input  aesr_pkg::block_t blk_i,
  input  logic             inv_i,
  input  logic             en_i,
  output aesr_pkg::block_t blk_o
);
  import aesr_pkg::*;
  always_comb begin
    blk_o = blk_i;
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        blk_o[c*4 +: 4] = mix_col(blk_i[c*4 +: 4], inv_i);
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/aes_round_datapath.sv
// aes round datapath: one round per word, three register stages.
// a word passes b1_q, b2_q and b3_q in turn before it is offered at the output;
// throughput one word per cycle while the output is not stalled.
// stage 1 substitution and row shift, stage 2 key add (encrypt mixes first),
// stage 3 inverse mix for decrypt. the pipeline stalls as a whole while the output word waits.
// reset clears valid bits and direction (encrypt); payload registers hold no reset.
`default_nettype none
`include "aes_round_datapath_macros.svh"
module aes_round_datapath (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i,
  aesr_stream_if.sink   in_i,
  aesr_stream_if.source out_o
);
  import aesr_pkg::*;

  logic dir_q;
  logic [2:0] v_q;
  logic adv;
  block_t b1_q, b2_q, b3_q, k1_q, blk_in, key_in, sub, shf, mixe, mixd, add_in;
  ctl_t c1_q, c2_q, c_in;
  logic [1:0] cmd;

  assign adv = out_o.ready || !v_q[2];
  assign in_i.ready = adv;
  assign cmd = in_i.data[257:256];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      blk_in[i]     = in_i.data[255 - 8*i -: 8];
      blk_in[8 + i] = in_i.data[191 - 8*i -: 8];
      key_in[i]     = in_i.data[127 - 8*i -: 8];
      key_in[8 + i] = in_i.data[63 - 8*i -: 8];
    end
    c_in.dir = dir_q;
    c_in.do_sub = (cmd == CMD_FULL) || (cmd == CMD_FINAL);
    c_in.do_mix = (cmd == CMD_FULL);
    // shift rows then sbox; sbox is bytewise so order is free
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (!dir_q) begin
          shf[r + 4*c] = blk_in[r + 4*((c + r) % 4)];
        end else begin
          shf[r + 4*((c + r) % 4)] = blk_in[r + 4*c];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sub[i] = dir_q ? INV_BOX[shf[i]] : FWD_BOX[shf[i]];
    end
  end

  aesr_mix u_mix_enc (
    .blk_i (b1_q),
    .inv_i (1'b0),
    .en_i  (c1_q.do_mix && !c1_q.dir),
    .blk_o (mixe)
  );
  assign add_in = mixe ^ k1_q;

  aesr_mix u_mix_dec (
    .blk_i (b2_q),
    .inv_i (1'b1),
    .en_i  (c2_q.do_mix && c2_q.dir),
    .blk_o (mixd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      v_q   <= '0;
      c1_q  <= '0;
      c2_q  <= '0;
    end else begin
      if (cfg_we_i) dir_q <= cfg_wdata_i;
      if (adv) begin
        v_q  <= {v_q[1:0], in_i.valid};
        c1_q <= c_in;
        c2_q <= c1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_q <= c_in.do_sub ? sub : blk_in;
      k1_q <= key_in;
      b2_q <= add_in;
      b3_q <= mixd;
    end
  end

  assign out_o.valid = v_q[2];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      out_o.data[127 - 8*i -: 8] = b3_q[i];
      out_o.data[63 - 8*i -: 8]  = b3_q[8 + i];
    end
  end

  `ASSERT_RST(a_in_ready, rst_ni, (!out_o.ready && out_o.valid) |-> !in_i.ready, "ready while stalled")
  `ASSERT_RST(a_hold, rst_ni, (out_o.valid && !out_o.ready) |=> out_o.valid, "output dropped")
  `ASSERT_RST(a_flow, rst_ni, (in_i.valid && in_i.ready) |=> v_q[0], "accepted word lost")
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// self-checking bench for aes_round_datapath: directed table, then random words
// depends on aesr_pkg, aesr_stream_if and the aes_round_datapath rtl
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aesr_pkg::*;

  localparam int unsigned IN_W = 2 + 4 * 64;
  localparam int unsigned OUT_W = 128;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct {
    logic         dir;
    cmd_e         cmd;
    logic [127:0] blk;
    logic [127:0] key;
    logic         fixed;
    logic [127:0] want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  aesr_stream_if #(.W(IN_W)) in_if ();
  aesr_stream_if #(.W(OUT_W)) out_if ();

  aes_round_datapath u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]   sub_fwd [256];
  logic [7:0]   sub_inv [256];
  logic         dir_now = 1'b0;
  logic         word_fixed = 1'b0;
  logic [127:0] word_want = '0;
  logic [127:0] expected_rounds [$];
  row_t         directed_rows [$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  words_out = 0;
  int unsigned  gap_max = 12;
  int unsigned  stall_max = 12;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // sbox from the field inverse and the affine map
  task automatic build_boxes();
    logic [7:0] iv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      iv = '0;
      for (int y = 1; y < 256; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) iv = y[7:0];
      s = iv ^ {iv[6:0], iv[7]} ^ {iv[5:0], iv[7:6]} ^ {iv[4:0], iv[7:5]}
          ^ {iv[3:0], iv[7:4]} ^ 8'h63;
      sub_fwd[x] = s;
      sub_inv[s] = x[7:0];
    end
  endtask

  function automatic logic [127:0] aes_round(input logic dir, input cmd_e cmd,
                                             input logic [127:0] blk,
                                             input logic [127:0] key);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] k [16];
    logic [7:0] kf [4];
    logic [127:0] r;
    logic do_round;
    logic do_mix;
    do_round = (cmd == CMD_FULL) || (cmd == CMD_FINAL);
    do_mix = (cmd == CMD_FULL);
    for (int i = 0; i < 16; i++) begin
      b[i] = blk[127 - 8 * i -: 8];
      k[i] = key[127 - 8 * i -: 8];
    end
    if (do_round) begin
      if (!dir) begin
        for (int i = 0; i < 16; i++) b[i] = sub_fwd[b[i]];
        for (int rw = 0; rw < 4; rw++)
          for (int c = 0; c < 4; c++) t[rw + 4 * c] = b[rw + 4 * ((c + rw) % 4)];
      end else begin
        for (int rw = 0; rw < 4; rw++)
          for (int c = 0; c < 4; c++) t[rw + 4 * ((c + rw) % 4)] = b[rw + 4 * c];
        for (int i = 0; i < 16; i++) t[i] = sub_inv[t[i]];
      end
      b = t;
    end
    if (do_mix) begin
      if (!dir) kf = '{8'd2, 8'd3, 8'd1, 8'd1};
      else kf = '{8'd14, 8'd11, 8'd13, 8'd9};
      // encrypt mixes before the key add, decrypt after
      if (dir) for (int i = 0; i < 16; i++) b[i] ^= k[i];
      for (int c = 0; c < 4; c++)
        for (int rw = 0; rw < 4; rw++) begin
          t[rw + 4 * c] = '0;
          for (int j = 0; j < 4; j++)
            t[rw + 4 * c] ^= gmul(b[j + 4 * c], kf[(j - rw + 4) % 4]);
        end
      b = t;
      if (!dir) for (int i = 0; i < 16; i++) b[i] ^= k[i];
    end else begin
      for (int i = 0; i < 16; i++) b[i] ^= k[i];
    end
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = b[i];
    return r;
  endfunction

  task automatic report(input string what, input logic [127:0] got,
                        input logic [127:0] want);
    $display("tb: %s got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic add_row(input logic dir, input cmd_e cmd, input logic [127:0] blk,
                         input logic [127:0] key, input logic fixed,
                         input logic [127:0] want);
    row_t r;
    r = '{dir, cmd, blk, key, fixed, want};
    directed_rows.push_back(r);
  endtask

  // wait on the clock first so the word accepted at the last edge is already queued
  task automatic wait_idle();
    @(posedge clk_i);
    while (expected_rounds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dir(input logic d);
    if (in_if.valid) in_if.valid <= 1'b0;
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    dir_now = d;
  endtask

  task automatic send_word(input cmd_e cmd, input logic [127:0] blk,
                           input logic [127:0] key, input logic fixed,
                           input logic [127:0] want);
    int unsigned gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= {cmd, blk, key};
    word_fixed <= fixed;
    word_want <= want;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
  endtask

  function automatic logic [127:0] rand_vec();
    logic [127:0] v;
    case ($urandom_range(9, 0))
      0: v = '0;
      1: v = '1;
      default: v = {$urandom, $urandom, $urandom, $urandom};
    endcase
    return v;
  endfunction

  // scoreboard: predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        words_out++;
        if (expected_rounds.size() == 0) begin
          report("unexpected word", out_if.data, '0);
        end else begin
          logic [127:0] w;
          w = expected_rounds.pop_front();
          if (out_if.data[127:64] != w[127:64]) report("result_hi", out_if.data, w);
          if (out_if.data[63:0] != w[63:0]) report("result_lo", out_if.data, w);
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (word_fixed) expected_rounds.push_back(word_want);
        else expected_rounds.push_back(aes_round(dir_now, cmd_e'(in_if.data[257:256]),
                                                 in_if.data[255:128], in_if.data[127:0]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // output side: random stalls, one long hold-off to back the pipe up
  initial begin
    int unsigned w;
    bit held;
    held = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      w = $urandom_range(stall_max, 0);
      if (!held && words_out > 400) begin
        w = 300;
        held = 1'b1;
      end
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  initial begin
    logic [127:0] s;
    logic [127:0] k;
    cmd_e c;
    in_if.valid = 1'b0;
    in_if.data = '0;
    build_boxes();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero block: every byte goes to 0x63 forward, 0x52 inverse, mixing keeps it
    add_row(1'b0, CMD_KEY, '0, '0, 1'b1, '0);
    add_row(1'b0, CMD_KEY, '1, '0, 1'b1, '1);
    add_row(1'b0, CMD_KEY, '1, '1, 1'b1, '0);
    add_row(1'b0, CMD_RSVD, '1, {8{16'h00ff}}, 1'b1, {8{16'hff00}});
    add_row(1'b0, CMD_FULL, '0, '0, 1'b1, {16{8'h63}});
    add_row(1'b0, CMD_FINAL, '0, '0, 1'b1, {16{8'h63}});
    add_row(1'b0, CMD_FULL, '0, '1, 1'b1, {16{8'h9c}});
    add_row(1'b0, CMD_FULL, '1, '1, 1'b0, '0);
    add_row(1'b0, CMD_FINAL, '1, '0, 1'b0, '0);
    add_row(1'b0, CMD_FULL, 128'h00112233445566778899aabbccddeeff, '0, 1'b0, '0);
    add_row(1'b0, CMD_FINAL, 128'h00112233445566778899aabbccddeeff,
            128'h0f0e0d0c0b0a09080706050403020100, 1'b0, '0);
    add_row(1'b0, CMD_RSVD, 128'h0123456789abcdef0123456789abcdef, '0, 1'b1,
            128'h0123456789abcdef0123456789abcdef);
    add_row(1'b1, CMD_KEY, 128'h5a5a5a5a5a5a5a5a5a5a5a5a5a5a5a5a, '1, 1'b1,
            128'ha5a5a5a5a5a5a5a5a5a5a5a5a5a5a5a5);
    add_row(1'b1, CMD_FULL, '0, '0, 1'b1, {16{8'h52}});
    add_row(1'b1, CMD_FINAL, '0, '0, 1'b1, {16{8'h52}});
    add_row(1'b1, CMD_FULL, '1, '1, 1'b0, '0);
    add_row(1'b1, CMD_FINAL, '1, '0, 1'b0, '0);
    add_row(1'b1, CMD_FULL, 128'h00112233445566778899aabbccddeeff,
            128'h0f0e0d0c0b0a09080706050403020100, 1'b0, '0);
    add_row(1'b1, CMD_FINAL, 128'h0123456789abcdef0123456789abcdef, '1, 1'b0, '0);
    add_row(1'b1, CMD_RSVD, '0, '1, 1'b1, '1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].dir != dir_now) set_dir(directed_rows[i].dir);
      send_word(directed_rows[i].cmd, directed_rows[i].blk, directed_rows[i].key,
                directed_rows[i].fixed, directed_rows[i].want);
    end

    // random phases alternate direction; some run back to back with no idling
    for (int ph = 0; ph < 6; ph++) begin
      set_dir(ph[0] ? 1'b0 : 1'b1);
      gap_max = (ph == 2) ? 0 : 12;
      stall_max = (ph == 4) ? 0 : 12;
      for (int n = 0; n < 200; n++) begin
        case ($urandom_range(9, 0))
          0, 1: c = CMD_KEY;
          2: c = CMD_RSVD;
          3, 4, 5: c = CMD_FINAL;
          default: c = CMD_FULL;
        endcase
        s = rand_vec();
        k = rand_vec();
        send_word(c, s, k, 1'b0, '0);
      end
    end
    set_dir(1'b0);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: aes_round_datapath.f
+incdir+rtl
rtl/aesr_pkg.sv
rtl/aesr_stream_if.sv
rtl/aesr_mix.sv
rtl/aes_round_datapath.sv
tb/tb_top.sv
